@@ hw/rtl/prs_pkg.sv @@
// Shared constants, codes and types of the pressure regulator scaler.
`default_nettype none

package prs_pkg;

    // Fixed scaling constants of the regulator interface.
    localparam int REGULATOR_SLOTS  = 2;
    localparam int SLOT_W           = (REGULATOR_SLOTS > 1) ? $clog2(REGULATOR_SLOTS) : 1;
    localparam int PWM_TOP          = 1023;
    localparam int CTRL_MAX_MV      = 10000;
    localparam int CTRL_MIN_MV      = 50;
    localparam int FEEDBACK_MIN_MV  = 1000;
    localparam int FEEDBACK_MAX_MV  = 5000;
    localparam int FEEDBACK_SPAN_MV = FEEDBACK_MAX_MV - FEEDBACK_MIN_MV;

    // Field and datapath widths.
    localparam int KPA_W     = 16;
    localparam int IDX_W     = 2;
    localparam int COUNT_W   = 2;
    localparam int DUTY_W    = 10;
    localparam int MV_W      = 14;
    localparam int PROD_W    = 32;
    localparam int QUO_W     = 21;
    localparam int QCNT_W    = 5;
    localparam int MUL_CNT_W = $clog2(KPA_W);
    localparam int SH_W      = 6;

    // Quotient lengths of the three divisions; each covers the largest quotient.
    localparam int MV_QBITS   = 14;
    localparam int DUTY_QBITS = 10;
    localparam int FB_QBITS   = 21;

    // Stream packing.
    localparam int IN_W     = 40;
    localparam int IN_USE_W = IDX_W + 2 * KPA_W;
    localparam int OUT_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Item kinds carried in tuser.
    localparam logic MODE_SET      = 1'b0;
    localparam logic MODE_FEEDBACK = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE = 3'd0,
        CFG_REG_COUNT  = 3'd1,
        CFG_MAX_CMD    = 3'd2,
        CFG_SET_OFF1   = 3'd3,
        CFG_SET_OFF2   = 3'd4,
        CFG_FB_OFF1    = 3'd5,
        CFG_FB_OFF2    = 3'd6
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMD_MUL,
        ST_CMD_DIV1,
        ST_CMD_DIV2,
        ST_FB_MUL,
        ST_FB_DIV,
        ST_DONE
    } state_t;

    // Start request to the serial divider.
    typedef struct packed {
        logic              start;
        logic [QCNT_W-1:0] qbits;
    } div_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pressure_regulator_scaler_top.sv @@
// Top level of the pressure regulator scaler: registers, sequencer and result stage.
//
// Usage: items enter on the s_ stream (tuser holds the mode, 0 set command,
// 1 feedback sample) and each item gives exactly one result item on the m_
// stream. Configuration registers are written through the cfg_ channel, which
// is always ready; write them only while no item is in flight.
// An invalid regulator, a rejected request, a clipped command or a feedback
// sample below the span start returns without arithmetic. A set command that
// needs scaling runs a 16-bit serial multiply, a 14-bit and a 10-bit serial
// division; the second division is skipped when the control voltage is below
// its minimum. A feedback sample runs a 16-bit multiply and a 21-bit division.
// One item is worked on at a time.
// The next item is taken while the previous result waits in the output
// register; a stalled receiver holds that register and, once the next result
// is ready, holds the sequencer until the output register frees.
// Reset (synchronous, active low) loads the register defaults, clears both
// stored requests and empties the output register.
`default_nettype none

module pressure_regulator_scaler_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: regulator_index[1:0], request_kpa[15:0], feedback_mv[15:0], zero pad
    input  logic [prs_pkg::IN_W-1:0]        s_tdata,
    // s_tuser: mode
    input  logic [0:0]                      s_tuser,
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: accepted, duty_valid, duty[9:0], measured_kpa[15:0],
    // stored_request_kpa[15:0], zero pad
    output logic [prs_pkg::OUT_W-1:0]       m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prs_pkg::KPA_W-1:0]       cfg_data
);
    import prs_pkg::*;

    // Configuration registers.
    logic [KPA_W-1:0]   full_scale_reg;
    logic [COUNT_W-1:0] reg_count_reg;
    logic [KPA_W-1:0]   max_cmd_reg;
    logic [KPA_W-1:0]   set_off1_reg;
    logic [KPA_W-1:0]   set_off2_reg;
    logic [KPA_W-1:0]   fb_off1_reg;
    logic [KPA_W-1:0]   fb_off2_reg;

    // Stored requests, one per regulator.
    logic [KPA_W-1:0]   stored_reg [REGULATOR_SLOTS];

    // Captured input item.
    logic               mode_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [KPA_W-1:0]   req_reg;
    logic [KPA_W-1:0]   fb_reg;

    // Sequencer, result and output registers.
    state_t             state_reg, state_next;
    logic               res_acc_reg, res_acc_next;
    logic               res_dv_reg, res_dv_next;
    logic [DUTY_W-1:0]  res_duty_reg, res_duty_next;
    logic [KPA_W-1:0]   res_meas_reg, res_meas_next;
    logic [KPA_W-1:0]   res_stored_reg, res_stored_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // Arithmetic units and their requests.
    logic               mul_start;
    logic [KPA_W-1:0]   mul_a;
    logic [KPA_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_product;
    logic               mul_done;
    div_ctrl_t          div_ctrl;
    logic [PROD_W-1:0]  div_dividend;
    logic [KPA_W-1:0]   div_divisor;
    logic [QUO_W-1:0]   div_quo;
    logic               div_done;

    // Decode of the captured item.
    logic               s_accept;
    logic               st_we;
    logic               idx_ok;
    logic [SLOT_W-1:0]  slot;
    logic [KPA_W-1:0]   stored_rd;
    logic [KPA_W-1:0]   set_off;
    logic [KPA_W-1:0]   fb_off;
    logic [KPA_W+1:0]   set_sum;
    logic [KPA_W-1:0]   p_kpa;
    logic               set_neg;
    logic               p_over_fs;
    logic               p_over_2fs;
    logic               fs_zero;
    logic               fb_low;
    logic [KPA_W-1:0]   fb_diff;
    logic [MV_W-1:0]    mv;
    logic               mv_low;
    logic [PROD_W-1:0]  duty_num;
    logic [QUO_W+2:0]   fb_sum;
    logic [KPA_W-1:0]   fb_sat;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= KPA_W'(1000);
            reg_count_reg  <= COUNT_W'(2);
            max_cmd_reg    <= KPA_W'(1000);
            set_off1_reg   <= '0;
            set_off2_reg   <= '0;
            fb_off1_reg    <= '0;
            fb_off2_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                CFG_REG_COUNT:  reg_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_MAX_CMD:    max_cmd_reg    <= cfg_data;
                CFG_SET_OFF1:   set_off1_reg   <= cfg_data;
                CFG_SET_OFF2:   set_off2_reg   <= cfg_data;
                CFG_FB_OFF1:    fb_off1_reg    <= cfg_data;
                CFG_FB_OFF2:    fb_off2_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Capture the input item.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser[0];
            idx_reg  <= s_tdata[IDX_W-1:0];
            req_reg  <= s_tdata[IDX_W+KPA_W-1:IDX_W];
            fb_reg   <= s_tdata[IN_USE_W-1:IDX_W+KPA_W];
        end
    end

    // Regulator decode: index counts from one.
    assign idx_ok    = (idx_reg != '0) && (idx_reg <= reg_count_reg)
                       && (int'(idx_reg) <= REGULATOR_SLOTS);
    assign slot      = SLOT_W'(idx_reg - 1'b1);
    assign stored_rd = stored_reg[slot];

    // Offsets exist only for the first two regulators.
    always_comb begin
        case (idx_reg)
            2'd1: begin
                set_off = set_off1_reg;
                fb_off  = fb_off1_reg;
            end
            2'd2: begin
                set_off = set_off2_reg;
                fb_off  = fb_off2_reg;
            end
            default: begin
                set_off = '0;
                fb_off  = '0;
            end
        endcase
    end

    // Set command: offset request and range checks against the full scale.
    assign set_sum    = {2'b00, req_reg} + {{2{set_off[KPA_W-1]}}, set_off};
    assign set_neg    = set_sum[KPA_W+1];
    assign p_kpa      = set_sum[KPA_W-1:0];
    assign p_over_2fs = ({1'b0, p_kpa} > {full_scale_reg, 1'b0});
    assign p_over_fs  = (p_kpa > full_scale_reg);
    assign fs_zero    = (full_scale_reg == '0);

    // Feedback: span start check.
    assign fb_low  = (fb_reg < KPA_W'(FEEDBACK_MIN_MV));
    assign fb_diff = fb_reg - KPA_W'(FEEDBACK_MIN_MV);

    // Control millivolts and the dividend of the duty scaling.
    assign mv       = div_quo[MV_W-1:0];
    assign mv_low   = (mv < MV_W'(CTRL_MIN_MV));
    assign duty_num = PROD_W'(mv) * PROD_W'(PWM_TOP);

    // Feedback kPa plus offset, saturated to the field range.
    assign fb_sum = {3'b000, div_quo} + {{(QUO_W+3-KPA_W){fb_off[KPA_W-1]}}, fb_off};
    always_comb begin
        if (fb_sum[QUO_W+2]) begin
            fb_sat = '0;
        end else if (fb_sum[QUO_W+1:KPA_W] != '0) begin
            fb_sat = '1;
        end else begin
            fb_sat = fb_sum[KPA_W-1:0];
        end
    end

    // Sequencer next state and unit requests.
    always_comb begin
        state_next      = state_reg;
        res_acc_next    = res_acc_reg;
        res_dv_next     = res_dv_reg;
        res_duty_next   = res_duty_reg;
        res_meas_next   = res_meas_reg;
        res_stored_next = res_stored_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        s_tready        = 1'b0;
        st_we           = 1'b0;
        mul_start       = 1'b0;
        mul_a           = full_scale_reg;
        mul_b           = fb_diff;
        div_ctrl.start  = 1'b0;
        div_ctrl.qbits  = QCNT_W'(FB_QBITS);
        div_dividend    = mul_product;
        div_divisor     = KPA_W'(FEEDBACK_SPAN_MV);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_acc_next    = 1'b0;
                res_dv_next     = 1'b0;
                res_duty_next   = '0;
                res_meas_next   = '0;
                res_stored_next = '0;
                state_next      = ST_DONE;
                if (idx_ok) begin
                    res_stored_next = stored_rd;
                    if (mode_reg == MODE_SET) begin
                        if (req_reg <= max_cmd_reg) begin
                            res_acc_next    = 1'b1;
                            res_dv_next     = 1'b1;
                            res_stored_next = req_reg;
                            st_we           = 1'b1;
                            if (set_neg || p_over_2fs || fs_zero) begin
                                res_duty_next = '0;
                            end else if (p_over_fs) begin
                                res_duty_next = DUTY_W'(PWM_TOP);
                            end else begin
                                mul_start  = 1'b1;
                                mul_a      = KPA_W'(CTRL_MAX_MV);
                                mul_b      = p_kpa;
                                state_next = ST_CMD_MUL;
                            end
                        end
                    end else begin
                        res_acc_next = 1'b1;
                        if (!fb_low) begin
                            mul_start  = 1'b1;
                            state_next = ST_FB_MUL;
                        end
                    end
                end
            end
            ST_CMD_MUL: begin
                if (mul_done) begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.qbits = QCNT_W'(MV_QBITS);
                    div_divisor    = full_scale_reg;
                    state_next     = ST_CMD_DIV1;
                end
            end
            ST_CMD_DIV1: begin
                if (div_done) begin
                    if (mv_low) begin
                        res_duty_next = '0;
                        state_next    = ST_DONE;
                    end else begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.qbits = QCNT_W'(DUTY_QBITS);
                        div_dividend   = duty_num;
                        div_divisor    = KPA_W'(CTRL_MAX_MV);
                        state_next     = ST_CMD_DIV2;
                    end
                end
            end
            ST_CMD_DIV2: begin
                if (div_done) begin
                    res_duty_next = div_quo[DUTY_W-1:0];
                    state_next    = ST_DONE;
                end
            end
            ST_FB_MUL: begin
                if (mul_done) begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_FB_DIV;
                end
            end
            ST_FB_DIV: begin
                if (div_done) begin
                    res_meas_next = fb_sat;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                // Move the result into the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_data_next = OUT_W'({res_stored_reg, res_meas_reg, res_duty_reg,
                                            res_dv_reg, res_acc_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Stored requests clear at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REGULATOR_SLOTS; i++) begin
                stored_reg[i] <= '0;
            end
        end else if (st_we) begin
            stored_reg[slot] <= req_reg;
        end
    end

    // Result and output payload.
    always_ff @(posedge aclk) begin
        res_acc_reg    <= res_acc_next;
        res_dv_reg     <= res_dv_next;
        res_duty_reg   <= res_duty_next;
        res_meas_reg   <= res_meas_next;
        res_stored_reg <= res_stored_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

    // Shared serial multiplier.
    prs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product),
        .done    (mul_done)
    );

    // Shared serial divider.
    prs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

endmodule

`default_nettype wire

@@ hw/rtl/prs_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module prs_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [prs_pkg::KPA_W-1:0]    a,
    input  logic [prs_pkg::KPA_W-1:0]    b,
    output logic [prs_pkg::PROD_W-1:0]   product,
    output logic                         done
);
    import prs_pkg::*;

    logic [KPA_W-1:0]     a_reg;
    logic [KPA_W-1:0]     hi_reg;
    logic [KPA_W-1:0]     lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [KPA_W-1:0]     addend;
    logic [KPA_W:0]       sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign addend = lo_reg[0] ? a_reg : '0;
    assign sum    = {1'b0, hi_reg} + {1'b0, addend};

    // Control: count the multiplier bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(KPA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the partial product shifts right into the multiplier register.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[KPA_W:1];
            lo_reg <= {sum[0], lo_reg[KPA_W-1:1]};
        end
    end

    assign product = {hi_reg, lo_reg};
    assign done    = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/prs_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module prs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  prs_pkg::div_ctrl_t           ctrl,
    input  logic [prs_pkg::PROD_W-1:0]   dividend,
    input  logic [prs_pkg::KPA_W-1:0]    divisor,
    output logic [prs_pkg::QUO_W-1:0]    quotient,
    output logic                         done
);
    import prs_pkg::*;

    logic [KPA_W-1:0]  rem_reg;
    logic [PROD_W-1:0] num_reg;
    logic [KPA_W-1:0]  d_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W-1:0] rem_init;
    logic [PROD_W-1:0] num_init;
    logic [SH_W-1:0]   low_shift;
    logic [KPA_W:0]    trial;
    logic [KPA_W:0]    diff;
    logic              ge;

    // The caller guarantees dividend < divisor * 2**qbits, so the bits above
    // the quotient length form a partial remainder already below the divisor.
    assign low_shift = SH_W'(PROD_W) - SH_W'(ctrl.qbits);
    assign rem_init  = dividend >> ctrl.qbits;
    assign num_init  = dividend << low_shift;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    // Control: count the quotient bits down.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.qbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == QCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, remaining dividend bits and quotient.
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= rem_init[KPA_W-1:0];
            num_reg <= num_init;
            d_reg   <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[KPA_W-1:0] : trial[KPA_W-1:0];
            num_reg <= {num_reg[PROD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/prs_checker.sv @@
// Port-level checks of the pressure regulator scaler, bound to its top level.
`default_nettype none

module prs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [prs_pkg::OUT_W-1:0]  m_tdata
);
    import prs_pkg::*;

    // A reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // A stalled result item holds its value.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // A rejected item carries no duty and no measurement.
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[27:1] == '0)
        else $error("rejected item carries duty or measurement");

    // A new duty comes only from an accepted set command, which measures nothing.
    a_duty_from_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[27:12] == '0)
        else $error("duty issued outside an accepted set command");

    // Only one item is worked on at a time, so the input closes after a take.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an item was taken");

endmodule

bind pressure_regulator_scaler_top prs_checker u_prs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
